FILE: design/ldpf_pkg.sv
package ldpf_pkg;

  // Shared multiplier geometry: signed operands, full-width product
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int OFFSET_W  = 22;
  localparam int SLOPE_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SLOPE_CH0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH1    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SLOPE_CH1 = 2'd3;

  localparam logic [SLOPE_W-1:0] INV_SLOPE_RESET = 24'd167772;

  // Operations
  localparam logic OP_PROCESS    = 1'b0;
  localparam logic OP_RESET_PEAK = 1'b1;

  // Level limits, snap threshold and exp input range
  localparam logic signed [23:0] LEVEL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] LEVEL_MIN = 24'sh800000;
  localparam logic [24:0]        SNAP_Q16  = 25'd22282;
  localparam logic signed [23:0] EXP_HI    = 24'sd800000;
  localparam logic signed [23:0] EXP_LO    = -24'sd800000;

  // Average: (8*old + 2*arg + 5) biased positive by 10*2^23, divided by 10
  localparam logic [28:0] AVG_BIAS   = 29'd83886085;
  localparam logic [28:0] RECIP10    = 29'd429496730;   // ceil(2^32/10)
  localparam int          RECIP10_SH = 32;
  localparam logic [24:0] LEVEL_HALF = 25'd8388608;

  // Exp range reduction
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic [24:0] EXP_K     = 25'd24204406;     // 2^54 / LN2_Q30
  localparam int          EXP_K_SH  = 40;
  localparam int          EXP_SCALE = 14;
  localparam logic [3:0]  TAY_LAST  = 4'd12;

  // Peak decay: floor(peak*19/20) = peak - floor(((peak + 19) >> 2) / 5)
  localparam logic [32:0] PEAK_ROUND = 33'd19;
  localparam logic [31:0] RECIP5     = 32'd3435973837;  // ceil(2^34/5)
  localparam int          RECIP5_SH  = 34;

  typedef struct packed {
    logic              operation;
    logic              channel;
    logic signed [15:0] sample;
  } ldpf_req_t;

  typedef struct packed {
    logic               out_channel;
    logic signed [23:0] log_level;
    logic [31:0]        power;
    logic [31:0]        peak;
  } ldpf_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARG_MUL,
    ST_ARG,
    ST_AVG_MUL,
    ST_AVG,
    ST_EXP_EST,
    ST_EXP_N,
    ST_EXP_R,
    ST_EXP_FIX,
    ST_TAY_B,
    ST_TAY_C,
    ST_EXP_SH,
    ST_PEAK_MUL,
    ST_PEAK,
    ST_DONE
  } ldpf_state_t;

  // Reciprocal of the Taylor index k: ceil(2^(30+l)/k), l = ceil(log2 k).
  // Exact floor division for numerators below 2^30.
  function automatic logic [30:0] taylor_recip(input logic [3:0] k);
    logic [30:0] m;
    unique case (k)
      4'd1:    m = 31'd1073741824;
      4'd2:    m = 31'd1073741824;
      4'd3:    m = 31'd1431655766;
      4'd4:    m = 31'd1073741824;
      4'd5:    m = 31'd1717986919;
      4'd6:    m = 31'd1431655766;
      4'd7:    m = 31'd1227133514;
      4'd8:    m = 31'd1073741824;
      4'd9:    m = 31'd1908874354;
      4'd10:   m = 31'd1717986919;
      4'd11:   m = 31'd1561806290;
      4'd12:   m = 31'd1431655766;
      default: m = 31'd1073741824;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] taylor_shift(input logic [3:0] k);
    logic [5:0] s;
    unique case (k)
      4'd1:                      s = 6'd30;
      4'd2:                      s = 6'd31;
      4'd3, 4'd4:                s = 6'd32;
      4'd5, 4'd6, 4'd7, 4'd8:    s = 6'd33;
      4'd9, 4'd10, 4'd11, 4'd12: s = 6'd34;
      default:                   s = 6'd30;
    endcase
    return s;
  endfunction

endpackage

FILE: design/ldpf_mul.sv
module ldpf_mul
  import ldpf_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  // Register the product; the sequencer consumes it on the next cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: design/log_detector_power_filter_core.sv
// Flow: a process request scales the sample, averages it with the stored level when the
// channel is seeded and the level does not snap, then sums a twelve-term exp series; a
// level outside the exp range skips the series, and a peak reset goes straight to the
// result. A request is taken only when idle, so a result stall holds off the next one.
// Reset: rst is synchronous, active high; it clears the channel state, restores the
// register defaults and drops any pending result.
module log_detector_power_filter_core
  import ldpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  ldpf_req_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output ldpf_rsp_t            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ldpf_state_t state, state_next;

  logic [OFFSET_W-1:0] offset_ch0, offset_ch1;
  logic [SLOPE_W-1:0]  inv_slope_ch0, inv_slope_ch1;

  logic signed [23:0] level_store [2];
  logic [31:0]        power_store [2];
  logic [31:0]        peak_store  [2];
  logic [1:0]         seeded;

  logic               op_r;
  logic               ch_r;
  logic signed [15:0] sample_r;
  logic signed [23:0] arg_r;
  logic signed [23:0] lvl_w;
  logic signed [5:0]  n_w;
  logic signed [31:0] r_w;
  logic [31:0]        e_w;
  logic [3:0]         k;
  logic [31:0]        power_w;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_u;

  ldpf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign prod_u = prod;

  // Request handshake and channel select
  logic req_take;
  logic rsp_load;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  logic [OFFSET_W-1:0] off_sel;
  logic [SLOPE_W-1:0]  inv_sel;
  logic signed [23:0]  old_level;
  logic [31:0]         old_peak;
  assign off_sel   = ch_r ? offset_ch1 : offset_ch0;
  assign inv_sel   = ch_r ? inv_slope_ch1 : inv_slope_ch0;
  assign old_level = level_store[ch_r];
  assign old_peak  = peak_store[ch_r];

  // Detector offset removal, 1/1024 mV units
  logic signed [23:0] d;
  assign d = {sample_r[15], sample_r, 7'd0} - {2'b00, off_sel};

  // Round and saturate the scaled level
  logic signed [PROD_W-1:0] arg_round, arg_sh;
  logic signed [23:0]       arg_sat;
  assign arg_round = prod + PROD_W'(131072);
  assign arg_sh    = arg_round >>> 18;
  always_comb begin
    if (arg_sh > PROD_W'(signed'(LEVEL_MAX))) begin
      arg_sat = LEVEL_MAX;
    end else if (arg_sh < PROD_W'(signed'(LEVEL_MIN))) begin
      arg_sat = LEVEL_MIN;
    end else begin
      arg_sat = arg_sh[23:0];
    end
  end

  // Snap test against the stored level
  logic signed [24:0] diff;
  logic [24:0]        abs_diff;
  logic               snap;
  assign diff     = {arg_sat[23], arg_sat} - {old_level[23], old_level};
  assign abs_diff = diff[24] ? 25'(-diff) : diff;
  assign snap     = abs_diff > SNAP_Q16;

  // Biased average numerator, always positive and below 2^28
  logic [28:0] avg_sum;
  assign avg_sum = ({{5{old_level[23]}}, old_level} << 3)
                 + ({{5{arg_r[23]}}, arg_r} << 1) + AVG_BIAS;

  // Range reduction helpers
  logic signed [5:0]  n_est;
  logic signed [37:0] x_q30;
  assign n_est = prod[EXP_K_SH+5:EXP_K_SH];
  assign x_q30 = {{14{lvl_w[23]}}, lvl_w} <<< EXP_SCALE;

  // Taylor term pieces
  logic [29:0] p_term;
  logic [30:0] t_term;
  assign p_term = prod_u[59:30];
  assign t_term = 31'(prod_u >> taylor_shift(k));

  // Final scaling of the series by 2^(n-14), rounding half up on right shifts
  logic signed [6:0] sh;
  logic [5:0]        sh_amt;
  logic [63:0]       e_ext, e_round, e_scaled;
  logic [31:0]       power_sat;
  assign sh      = {n_w[5], n_w} - 7'sd14;
  assign sh_amt  = sh[6] ? 6'(-sh) : 6'(sh);
  assign e_ext   = {32'd0, e_w};
  assign e_round = 64'd1 << (sh_amt - 6'd1);
  assign e_scaled = sh[6] ? ((e_ext + e_round) >> sh_amt) : (e_ext << sh_amt);
  assign power_sat = (e_scaled[63:32] != 32'd0) ? 32'hFFFFFFFF : e_scaled[31:0];

  // Peak decay helpers
  logic [32:0] peak_bias;
  logic [30:0] peak_y;
  logic [31:0] peak_q, peak_dec, peak_new;
  assign peak_bias = {1'b0, old_peak} + PEAK_ROUND;
  assign peak_y    = peak_bias[32:2];
  assign peak_q    = prod_u[RECIP5_SH+31:RECIP5_SH];
  assign peak_dec  = old_peak - peak_q;
  assign peak_new  = (power_w > peak_dec) ? power_w : peak_dec;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer and steer the shared multiplier
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = (req.operation == OP_RESET_PEAK) ? ST_DONE : ST_ARG_MUL;
        end
      end
      ST_ARG_MUL: begin
        mul_a      = {{9{d[23]}}, d};
        mul_b      = {9'd0, inv_sel};
        state_next = ST_ARG;
      end
      ST_ARG: begin
        state_next = (seeded[ch_r] && !snap) ? ST_AVG_MUL : ST_EXP_EST;
      end
      ST_AVG_MUL: begin
        mul_a      = {5'd0, avg_sum[27:0]};
        mul_b      = {4'd0, RECIP10};
        state_next = ST_AVG;
      end
      ST_AVG: begin
        state_next = ST_EXP_EST;
      end
      ST_EXP_EST: begin
        mul_a = {{9{lvl_w[23]}}, lvl_w};
        mul_b = {8'd0, EXP_K};
        if (lvl_w > EXP_HI || lvl_w < EXP_LO) begin
          state_next = ST_PEAK_MUL;
        end else begin
          state_next = ST_EXP_N;
        end
      end
      ST_EXP_N: begin
        mul_a      = {{27{n_est[5]}}, n_est};
        mul_b      = {3'd0, LN2_Q30};
        state_next = ST_EXP_R;
      end
      ST_EXP_R: begin
        state_next = ST_EXP_FIX;
      end
      ST_EXP_FIX: begin
        mul_a = {2'd0, ONE_Q30};
        mul_b = {3'd0, r_w[29:0]};
        if (!r_w[31] && (r_w < $signed({2'b00, LN2_Q30}))) begin
          state_next = ST_TAY_B;
        end
      end
      ST_TAY_B: begin
        mul_a      = {3'd0, p_term};
        mul_b      = {2'd0, taylor_recip(k)};
        state_next = ST_TAY_C;
      end
      ST_TAY_C: begin
        mul_a      = {2'd0, t_term};
        mul_b      = {3'd0, r_w[29:0]};
        state_next = (k == TAY_LAST) ? ST_EXP_SH : ST_TAY_B;
      end
      ST_EXP_SH: begin
        state_next = ST_PEAK_MUL;
      end
      ST_PEAK_MUL: begin
        mul_a      = {2'd0, peak_y};
        mul_b      = {1'b0, RECIP5};
        state_next = seeded[ch_r] ? ST_PEAK : ST_DONE;
      end
      ST_PEAK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_ch0    <= '0;
      inv_slope_ch0 <= INV_SLOPE_RESET;
      offset_ch1    <= '0;
      inv_slope_ch1 <= INV_SLOPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_CH0:    offset_ch0    <= cfg_data[OFFSET_W-1:0];
        REG_INV_SLOPE_CH0: inv_slope_ch0 <= cfg_data[SLOPE_W-1:0];
        REG_OFFSET_CH1:    offset_ch1    <= cfg_data[OFFSET_W-1:0];
        REG_INV_SLOPE_CH1: inv_slope_ch1 <= cfg_data[SLOPE_W-1:0];
        default:           offset_ch0    <= offset_ch0;
      endcase
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          op_r     <= req.operation;
          ch_r     <= req.channel;
          sample_r <= req.sample;
        end
      end
      ST_ARG: begin
        arg_r <= arg_sat;
        lvl_w <= arg_sat;
      end
      ST_AVG: begin
        lvl_w <= 24'(prod_u[RECIP10_SH+24:RECIP10_SH] - LEVEL_HALF);
      end
      ST_EXP_EST: begin
        if (lvl_w > EXP_HI) begin
          power_w <= 32'hFFFFFFFF;
        end else if (lvl_w < EXP_LO) begin
          power_w <= 32'd0;
        end
      end
      ST_EXP_N: begin
        n_w <= n_est;
      end
      ST_EXP_R: begin
        r_w <= 32'(x_q30 - prod[37:0]);
      end
      ST_EXP_FIX: begin
        // Step the quotient until the residue lands in [0, ln2)
        if (r_w[31]) begin
          r_w <= r_w + $signed({2'b00, LN2_Q30});
          n_w <= n_w - 6'sd1;
        end else if (r_w >= $signed({2'b00, LN2_Q30})) begin
          r_w <= r_w - $signed({2'b00, LN2_Q30});
          n_w <= n_w + 6'sd1;
        end else begin
          e_w <= {1'b0, ONE_Q30};
          k   <= 4'd1;
        end
      end
      ST_TAY_C: begin
        e_w <= e_w + {1'b0, t_term};
        if (k != TAY_LAST) begin
          k <= k + 4'd1;
        end
      end
      ST_EXP_SH: begin
        power_w <= power_sat;
      end
      default: begin
        k <= k;
      end
    endcase
  end

  // Update the per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        level_store[i] <= '0;
        power_store[i] <= '0;
        peak_store[i]  <= '0;
      end
      seeded <= '0;
    end else begin
      if (req_take && req.operation == OP_RESET_PEAK) begin
        peak_store[0] <= '0;
        peak_store[1] <= '0;
      end
      if (state == ST_PEAK_MUL && !seeded[ch_r]) begin
        level_store[ch_r] <= lvl_w;
        power_store[ch_r] <= power_w;
        peak_store[ch_r]  <= power_w;
        seeded[ch_r]      <= 1'b1;
      end
      if (state == ST_PEAK) begin
        level_store[ch_r] <= lvl_w;
        power_store[ch_r] <= power_w;
        peak_store[ch_r]  <= peak_new;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.out_channel <= ch_r;
      rsp.log_level   <= level_store[ch_r];
      rsp.power       <= power_store[ch_r];
      rsp.peak        <= peak_store[ch_r];
    end
  end

`ifndef SYNTHESIS
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done step");

  a_peak_reset: assert property (@(posedge clk) disable iff (rst)
    (req_take && req.operation == OP_RESET_PEAK) |=>
      (peak_store[0] == 32'd0 && peak_store[1] == 32'd0))
    else $error("peak reset did not clear both peaks");

  a_tay_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAY_B || state == ST_TAY_C) |-> (k >= 4'd1 && k <= TAY_LAST))
    else $error("series index out of range");

  a_residue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAY_B && $past(state) == ST_EXP_FIX) |->
      (!r_w[31] && r_w < $signed({2'b00, LN2_Q30})))
    else $error("series started with an unreduced residue");

  a_peak_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && op_r == OP_PROCESS) |->
      peak_store[ch_r] >= power_store[ch_r])
    else $error("peak below power after update");
`endif

endmodule
